// ===== rtl/stb_pkg.sv =====
// Shared constants, codes and types for the software timer bank.
package stb_pkg;

   // Bank geometry and field widths
   localparam int unsigned NUM_TIMERS = 16;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned CNT_W      = IDX_W + 1;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned STEP_W     = 16;
   localparam int unsigned CMD_W      = 2;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(100);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

   // Result kinds
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_EXPIRED = 1'b1;

   // Access requests towards the slot memories
   typedef struct packed {
      logic              rem_we;
      logic [IDX_W-1:0]  rem_waddr;
      logic [TIME_W-1:0] rem_wdata;
      logic [IDX_W-1:0]  rem_raddr;
      logic              rld_we;
      logic [IDX_W-1:0]  rld_addr;
      logic [TIME_W-1:0] rld_wdata;
   } mem_req_type;

endpackage

// ===== rtl/stb_slot_mem.sv =====
// Remaining-time and reload-time memories of the timer slots.
module stb_slot_mem
   import stb_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [TIME_W-1:0] rem_rdata,
   output logic [TIME_W-1:0] rld_rdata
);

   logic [TIME_W-1:0] rem_mem [NUM_TIMERS];
   logic [TIME_W-1:0] rld_mem [NUM_TIMERS];

   // Remaining time: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rem_we) begin
         rem_mem[mem_req.rem_waddr] <= mem_req.rem_wdata;
      end
      rem_rdata <= rem_mem[mem_req.rem_raddr];
   end

   // Reload time: single address, read-before-write
   always_ff @(posedge clock) begin
      if (mem_req.rld_we) begin
         rld_mem[mem_req.rld_addr] <= mem_req.rld_wdata;
      end
      rld_rdata <= rld_mem[mem_req.rld_addr];
   end

endmodule

// ===== rtl/soft_timer_bank_core.sv =====
// Top level of the software timer bank: command sequencer, slot scan and result register.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------------------
//   request   req_command/timer_id/period    word taken when start high, busy low
//   response  rsp_kind/expired_id/rejected/  one word per cycle while rsp_valid high,
//             rsp_time_now/rsp_last          no back-pressure
//   config    csr_wdata                      tick step written when csr_we high
//
// Start, stop and restart pass through the command state, which registers the
// acknowledge word. A tick keeps busy high while it issues one remaining-time read per
// slot through the single memory read port, drains the processing stage and sends the
// closing word. Synchronous reset clears control state, armed and reload-written flags;
// slot memories need no clearing pass. The receiver cannot stall.
module soft_timer_bank_core
   import stb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [IDX_W-1:0]  req_timer_id,
   input  logic [TIME_W-1:0] req_period,
   output logic              rsp_valid,
   output logic              rsp_kind,
   output logic [IDX_W-1:0]  rsp_expired_id,
   output logic              rsp_rejected,
   output logic [TIME_W-1:0] rsp_time_now,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [STEP_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_CLOSE = 2'd2;
   localparam logic [1:0] ST_CMD   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]      p_idx_ff, p_idx_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [IDX_W-1:0]      id_ff, id_in;
   logic [TIME_W-1:0]     period_ff, period_in;
   logic [TIME_W-1:0]     time_base_ff, time_base_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [NUM_TIMERS-1:0] rld_vld_ff, rld_vld_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                  rsp_rej_ff, rsp_rej_in;
   logic [TIME_W-1:0]     rsp_time_ff, rsp_time_in;
   logic                  rsp_last_ff, rsp_last_in;

   mem_req_type           mem_req;
   logic [TIME_W-1:0]     rem_rdata;
   logic [TIME_W-1:0]     rld_rdata;
   logic [TIME_W-1:0]     step_ext;
   logic                  accept;
   logic                  in_bank;

   stb_slot_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rem_rdata (rem_rdata),
      .rld_rdata (rld_rdata)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign step_ext = TIME_W'(step_ff);
   assign in_bank  = (int'(id_ff) < NUM_TIMERS);

   // Sequencer, slot read-modify-write and result word
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      p_vld_in     = 1'b0;
      p_idx_in     = p_idx_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      period_in    = period_ff;
      time_base_in = time_base_ff;
      step_in      = csr_we ? csr_wdata : step_ff;
      armed_in     = armed_ff;
      rld_vld_in   = rld_vld_ff;

      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_ACK;
      rsp_id_in    = '0;
      rsp_rej_in   = 1'b0;
      rsp_time_in  = time_base_ff;
      rsp_last_in  = 1'b0;

      mem_req           = '0;
      mem_req.rem_raddr = cnt_ff[IDX_W-1:0];
      mem_req.rld_addr  = id_ff;

      // Processing stage: read data for slot p_idx is back
      if (p_vld_ff && armed_ff[p_idx_ff]) begin
         mem_req.rem_we    = 1'b1;
         mem_req.rem_waddr = p_idx_ff;
         if (rem_rdata <= step_ext) begin
            mem_req.rem_wdata  = '0;
            armed_in[p_idx_ff] = 1'b0;
            rsp_valid_in       = 1'b1;
            rsp_kind_in        = KIND_EXPIRED;
            rsp_id_in          = p_idx_ff;
         end else begin
            mem_req.rem_wdata = rem_rdata - step_ext;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            mem_req.rld_addr = req_timer_id;
            if (accept) begin
               cmd_in    = req_command;
               id_in     = req_timer_id;
               period_in = req_period;
               if (req_command == CMD_TICK) begin
                  time_base_in = time_base_ff + step_ext;
                  cnt_in       = '0;
                  state_in     = ST_SCAN;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_SCAN: begin
            if (int'(cnt_ff) < NUM_TIMERS) begin
               p_vld_in = 1'b1;
               p_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in   = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CMD: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = id_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
            if (in_bank) begin
               unique case (cmd_ff)
                  CMD_START: begin
                     if (period_ff < step_ext) begin
                        rsp_rej_in = 1'b1;
                     end else begin
                        mem_req.rem_we    = 1'b1;
                        mem_req.rem_waddr = id_ff;
                        mem_req.rem_wdata = period_ff;
                        mem_req.rld_we    = 1'b1;
                        mem_req.rld_wdata = period_ff;
                        rld_vld_in[id_ff] = 1'b1;
                        armed_in[id_ff]   = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     armed_in[id_ff] = 1'b0;
                  end
                  CMD_RESTART: begin
                     // never-written reload reads as zero
                     mem_req.rem_we    = 1'b1;
                     mem_req.rem_waddr = id_ff;
                     mem_req.rem_wdata = rld_vld_ff[id_ff] ? rld_rdata : '0;
                     armed_in[id_ff]   = 1'b1;
                  end
                  CMD_TICK: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         p_vld_ff     <= 1'b0;
         time_base_ff <= '0;
         step_ff      <= STEP_RESET;
         armed_ff     <= '0;
         rld_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p_vld_ff     <= p_vld_in;
         time_base_ff <= time_base_in;
         step_ff      <= step_in;
         armed_ff     <= armed_in;
         rld_vld_ff   <= rld_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_idx_ff    <= p_idx_in;
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      period_ff   <= period_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_rej_ff  <= rsp_rej_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_rejected   = rsp_rej_ff;
   assign rsp_time_now   = rsp_time_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   // Closing or acknowledge word only once the sequencer is back to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last word while sequencer busy");

   // Expiry words only during a tick scan
   a_expiry_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> busy)
      else $error("expiry word outside a tick");

   // An accepted word always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // Processing stage only runs inside the scan
   a_proc_scan: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> (state_ff == ST_SCAN))
      else $error("slot processed outside scan");
`endif

endmodule
